[sv/icmms_pkg.sv]
// Shared types and constants of the crop, mirror and mean-subtract block.
// Used by icmms_cfg, icmms_window and the top level; depends on nothing.
package icmms_pkg;

    localparam int NUM_COLOR = 3;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    localparam logic [1:0] MEAN_NONE    = 2'd0;
    localparam logic [1:0] MEAN_CHANNEL = 2'd1;
    localparam logic [1:0] MEAN_ELEMENT = 2'd2;

    localparam logic [2:0] REG_CROP_HEIGHT = 3'd0;
    localparam logic [2:0] REG_CROP_WIDTH  = 3'd1;
    localparam logic [2:0] REG_COLOR_MODE  = 3'd2;
    localparam logic [2:0] REG_MEAN_MODE   = 3'd3;
    localparam logic [2:0] REG_MEAN_ZERO   = 3'd4;
    localparam logic [2:0] REG_MEAN_ONE    = 3'd5;
    localparam logic [2:0] REG_MEAN_TWO    = 3'd6;

    localparam logic [8:0]  RST_CROP_HEIGHT = 9'd224;
    localparam logic [8:0]  RST_CROP_WIDTH  = 9'd224;
    localparam logic        RST_COLOR_MODE  = 1'b1;
    localparam logic [1:0]  RST_MEAN_MODE   = MEAN_NONE;
    localparam logic [15:0] RST_MEAN        = 16'd0;

    typedef struct packed {
        logic [8:0]  crop_height;
        logic [8:0]  crop_width;
        logic        color_mode;
        logic [1:0]  mean_mode;
        logic [15:0] mean_zero;
        logic [15:0] mean_one;
        logic [15:0] mean_two;
    } icmms_cfg_t;

endpackage

[sv/icmms_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module icmms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

[sv/icmms_cfg.sv]
// Configuration register file of the crop, mirror and mean-subtract block.
// Depends on icmms_pkg.
module icmms_cfg
    import icmms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output icmms_cfg_t  cfg
);

    icmms_cfg_t cfg_reg;
    icmms_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CROP_HEIGHT: cfg_next.crop_height = cfg_data[8:0];
                REG_CROP_WIDTH:  cfg_next.crop_width  = cfg_data[8:0];
                REG_COLOR_MODE:  cfg_next.color_mode  = cfg_data[0];
                REG_MEAN_MODE:   cfg_next.mean_mode   = cfg_data[1:0];
                REG_MEAN_ZERO:   cfg_next.mean_zero   = cfg_data;
                REG_MEAN_ONE:    cfg_next.mean_one    = cfg_data;
                REG_MEAN_TWO:    cfg_next.mean_two    = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crop_height <= RST_CROP_HEIGHT;
            cfg_reg.crop_width  <= RST_CROP_WIDTH;
            cfg_reg.color_mode  <= RST_COLOR_MODE;
            cfg_reg.mean_mode   <= RST_MEAN_MODE;
            cfg_reg.mean_zero   <= RST_MEAN;
            cfg_reg.mean_one    <= RST_MEAN;
            cfg_reg.mean_two    <= RST_MEAN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

[sv/icmms_window.sv]
// Crop window test and crop coordinates for one sample.
// Depends on icmms_pkg.
module icmms_window
    import icmms_pkg::*;
#(
    parameter int MAX_CROP_HEIGHT = 256,
    parameter int MAX_CROP_WIDTH  = 256,
    parameter int MAX_IMAGE_DIM   = 1024
) (
    input  icmms_cfg_t  cfg,
    input  logic [9:0]  row,
    input  logic [9:0]  col,
    input  logic [1:0]  channel,
    input  logic [9:0]  row_offset,
    input  logic [9:0]  col_offset,
    input  logic        mirror,
    output logic        inside_win,
    output logic [$clog2(NUM_COLOR*MAX_CROP_HEIGHT)-1:0] row_sel,
    output logic [((MAX_CROP_WIDTH > 1) ? $clog2(MAX_CROP_WIDTH) : 1)-1:0] crop_col,
    output logic [((MAX_CROP_WIDTH > 1) ? $clog2(MAX_CROP_WIDTH) : 1)-1:0] col_sel,
    output logic [$clog2(MAX_CROP_WIDTH+1)-1:0] width_eff
);

    localparam int RSW = $clog2(NUM_COLOR*MAX_CROP_HEIGHT);
    localparam int CW  = (MAX_CROP_WIDTH > 1) ? $clog2(MAX_CROP_WIDTH) : 1;
    localparam int WW  = $clog2(MAX_CROP_WIDTH+1);

    logic [31:0] h32;
    logic [31:0] w32;
    logic [9:0]  r_full;
    logic [9:0]  c_full;
    logic        ch_ok;
    logic        src_ok;
    logic [RSW-1:0] ch_base;

    always_comb
    begin
        h32 = (32'(cfg.crop_height) > 32'(MAX_CROP_HEIGHT)) ?
              32'(MAX_CROP_HEIGHT) : 32'(cfg.crop_height);
        w32 = (32'(cfg.crop_width) > 32'(MAX_CROP_WIDTH)) ?
              32'(MAX_CROP_WIDTH) : 32'(cfg.crop_width);

        ch_ok  = cfg.color_mode ? (32'(channel) < 32'(NUM_COLOR)) : (channel == 2'd0);
        src_ok = (32'(row) < 32'(MAX_IMAGE_DIM)) && (32'(col) < 32'(MAX_IMAGE_DIM));

        r_full = row - row_offset;
        c_full = col - col_offset;

        inside_win = ch_ok && src_ok && (row >= row_offset) && (col >= col_offset) &&
                     (32'(r_full) < h32) && (32'(c_full) < w32);

        case (channel)
            2'd1:    ch_base = RSW'(h32);
            2'd2:    ch_base = RSW'(h32 << 1);
            default: ch_base = '0;
        endcase

        row_sel   = ch_base + RSW'(r_full);
        crop_col  = CW'(c_full);
        col_sel   = mirror ? CW'(w32 - 32'd1 - 32'(c_full)) : CW'(c_full);
        width_eff = WW'(w32);
    end

endmodule

[sv/image_crop_mirror_mean_subtract.sv]
// Top level of the crop, mirror and mean-subtract block: a five-stage pipeline.
// Depends on icmms_pkg, icmms_cfg, icmms_window and icmms_ram.
//
//   Channel  | Handshake                 | Payload
//   item     | item_valid/item_stall     | action row col channel sample row_offset
//            |                           | col_offset mirror table_index mean_value
//   result   | result_valid/result_stall | target_index value
//   cfg      | cfg_valid/cfg_ready       | cfg_index cfg_data
//
// One item is accepted per cycle while item_stall is low; a pixel result then passes through
// stages two, three and four to the output register, whose valid bit drives result_valid.
// The single port of the mean table is used once per item, so it does not limit the rate.
// Reset clears the valid bits and the configuration registers; the data registers and the
// mean table are not cleared.
// A stall on the result side fills the empty stages first, then stalls the input.
module image_crop_mirror_mean_subtract
    import icmms_pkg::*;
#(
    parameter int MAX_CROP_HEIGHT = 256,
    parameter int MAX_CROP_WIDTH  = 256,
    parameter int MAX_IMAGE_DIM   = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  logic         action,
    input  logic [9:0]   row,
    input  logic [9:0]   col,
    input  logic [1:0]   channel,
    input  logic [7:0]   sample,
    input  logic [9:0]   row_offset,
    input  logic [9:0]   col_offset,
    input  logic         mirror,
    input  logic [17:0]  table_index,
    input  logic [15:0]  mean_value,
    output logic         result_valid,
    input  logic         result_stall,
    output logic [17:0]  target_index,
    output logic signed [16:0] value,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int TABLE_DEPTH = NUM_COLOR * MAX_CROP_HEIGHT * MAX_CROP_WIDTH;
    localparam int IDXW = $clog2(TABLE_DEPTH);
    localparam int XW   = (IDXW > 18) ? IDXW : 18;
    localparam int RSW  = $clog2(NUM_COLOR*MAX_CROP_HEIGHT);
    localparam int CW   = (MAX_CROP_WIDTH > 1) ? $clog2(MAX_CROP_WIDTH) : 1;
    localparam int WW   = $clog2(MAX_CROP_WIDTH+1);

    icmms_cfg_t cfg;

    logic ld1, ld2, ld3, ld4, ld_o;
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;

    logic        act1_reg;
    logic [9:0]  row1_reg, col1_reg, roff1_reg, coff1_reg;
    logic [1:0]  ch1_reg;
    logic [7:0]  smp1_reg;
    logic        mir1_reg;
    logic [17:0] midx1_reg;
    logic [15:0] mval1_reg;

    logic           act2_reg;
    logic [1:0]     ch2_reg;
    logic [7:0]     smp2_reg;
    logic [CW-1:0]  c2_reg, cs2_reg;
    logic [RSW-1:0] rs2_reg;
    logic [17:0]    midx2_reg;
    logic [15:0]    mval2_reg;

    logic            act3_reg;
    logic [1:0]      ch3_reg;
    logic [7:0]      smp3_reg;
    logic [CW-1:0]   c3_reg, cs3_reg;
    logic [IDXW-1:0] base3_reg;
    logic [17:0]     midx3_reg;
    logic [15:0]     mval3_reg;

    logic [1:0]  ch4_reg;
    logic [7:0]  smp4_reg;
    logic [17:0] tidx4_reg;

    logic [17:0] tidx_o_reg;
    logic [16:0] value_o_reg;

    logic           inside_win;
    logic [RSW-1:0] row_sel;
    logic [CW-1:0]  crop_col, col_sel;
    logic [WW-1:0]  width_eff;

    logic [RSW+WW-1:0] prod;
    logic [XW-1:0]     tidx_full;
    logic [XW-1:0]     midx_ext;
    logic [IDXW-1:0]   rd_addr, ram_addr;
    logic              ram_we;
    logic [15:0]       ram_rdata;
    logic [15:0]       mean;
    logic [16:0]       value_next;

    icmms_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    icmms_window #(
        .MAX_CROP_HEIGHT (MAX_CROP_HEIGHT),
        .MAX_CROP_WIDTH  (MAX_CROP_WIDTH),
        .MAX_IMAGE_DIM   (MAX_IMAGE_DIM)
    ) u_window (
        .cfg        (cfg),
        .row        (row1_reg),
        .col        (col1_reg),
        .channel    (ch1_reg),
        .row_offset (roff1_reg),
        .col_offset (coff1_reg),
        .mirror     (mir1_reg),
        .inside_win (inside_win),
        .row_sel    (row_sel),
        .crop_col   (crop_col),
        .col_sel    (col_sel),
        .width_eff  (width_eff)
    );

    // Each stage loads when it is empty or its successor loads.
    assign ld_o = !vo_reg || !result_stall;
    assign ld4  = !v4_reg || ld_o;
    assign ld3  = !v3_reg || ld4;
    assign ld2  = !v2_reg || ld3;
    assign ld1  = !v1_reg || ld2;
    assign item_stall = !ld1;

    assign prod      = (RSW+WW)'(rs2_reg) * (RSW+WW)'(width_eff);
    assign tidx_full = XW'(base3_reg) + XW'(cs3_reg);
    assign rd_addr   = base3_reg + IDXW'(c3_reg);
    assign midx_ext  = XW'(midx3_reg);
    assign ram_addr  = (act3_reg == ACT_LOAD) ? midx_ext[IDXW-1:0] : rd_addr;
    assign ram_we    = v3_reg && (act3_reg == ACT_LOAD) && ld4 &&
                       (32'(midx3_reg) < 32'(TABLE_DEPTH));

    icmms_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH)
    ) u_mean_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ld4),
        .addr  (ram_addr),
        .wdata (mval3_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        case (cfg.mean_mode)
            MEAN_CHANNEL:
            begin
                case (ch4_reg)
                    2'd0:    mean = cfg.mean_zero;
                    2'd1:    mean = cfg.mean_one;
                    default: mean = cfg.mean_two;
                endcase
            end
            MEAN_ELEMENT: mean = ram_rdata;
            default:      mean = 16'd0;
        endcase
        value_next = {1'b0, smp4_reg, 8'h00} - {1'b0, mean};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= item_valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg && ((act1_reg == ACT_LOAD) || inside_win);
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                v4_reg <= v3_reg && (act3_reg == ACT_PIXEL);
            end
            if (ld_o)
            begin
                vo_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            act1_reg  <= action;
            row1_reg  <= row;
            col1_reg  <= col;
            ch1_reg   <= channel;
            smp1_reg  <= sample;
            roff1_reg <= row_offset;
            coff1_reg <= col_offset;
            mir1_reg  <= mirror;
            midx1_reg <= table_index;
            mval1_reg <= mean_value;
        end
        if (ld2)
        begin
            act2_reg  <= act1_reg;
            ch2_reg   <= ch1_reg;
            smp2_reg  <= smp1_reg;
            c2_reg    <= crop_col;
            cs2_reg   <= col_sel;
            rs2_reg   <= row_sel;
            midx2_reg <= midx1_reg;
            mval2_reg <= mval1_reg;
        end
        if (ld3)
        begin
            act3_reg  <= act2_reg;
            ch3_reg   <= ch2_reg;
            smp3_reg  <= smp2_reg;
            c3_reg    <= c2_reg;
            cs3_reg   <= cs2_reg;
            base3_reg <= IDXW'(prod);
            midx3_reg <= midx2_reg;
            mval3_reg <= mval2_reg;
        end
        if (ld4)
        begin
            ch4_reg   <= ch3_reg;
            smp4_reg  <= smp3_reg;
            tidx4_reg <= tidx_full[17:0];
        end
        if (ld_o)
        begin
            tidx_o_reg  <= tidx4_reg;
            value_o_reg <= value_next;
        end
    end

    assign result_valid = vo_reg;
    assign target_index = tidx_o_reg;
    assign value        = $signed(value_o_reg);

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && vo_reg))
        else $error("input stalled while the pipeline has an empty stage");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> v1_reg)
        else $error("accepted item missing from the input stage");

    a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && ld_o) |=> vo_reg)
        else $error("result lost between the mean stage and the output register");

    a_write_not_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we) |=> !v4_reg || $past(v3_reg && ld4 && v4_reg && !ld_o))
        else $error("table write produced a result");

endmodule
